>>> src/dta_pkg.sv
// ---------------------------------------------------------------------------
// dta_pkg: shared types and constants for the decimal ASCII converter
// Widths, ASCII codes, queue entry and back-end state encoding.
// ---------------------------------------------------------------------------
package dta_pkg;

   localparam int ValueWidth = 32;
   localparam int NumDigits  = 10;
   localparam int BcdWidth   = NumDigits * 4;
   localparam int StepWidth  = $clog2(ValueWidth);
   localparam int IdxWidth   = $clog2(NumDigits);
   localparam int QueueDepth = 2;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   localparam logic [7:0] AsciiZero  = 8'd48;
   localparam logic [7:0] AsciiMinus = 8'd45;

   // shift-add-3 correction
   localparam logic [3:0] AdjThreshold = 4'd5;
   localparam logic [3:0] AdjOffset    = 4'd3;

   typedef struct packed {
      logic                  neg;
      logic [ValueWidth-1:0] mag;
   } dta_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } dta_state_type;

endpackage

>>> src/signed_int_to_decimal_ascii_top.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: 32-bit signed integer to decimal ASCII
// Emits the decimal text of each input word, one character per output word.
// ---------------------------------------------------------------------------
// Each request word is a two's complement 32-bit integer; the response side
// delivers its decimal text one ASCII character per word, most significant
// digit first, with rsp_last set on the final character. Negative numbers
// start with '-', zero is the single character '0', and -2147483648 comes
// out right (eleven characters). The back end loads a number, runs the
// bit-serial shift-add-3 over all 32 bits, then emits the characters;
// the serial BCD loop dominates the time taken per number.
// The front register and a two-entry queue absorb up to three further words
// while a conversion runs, so the request side stalls only when those fill.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dta_pkg::ValueWidth-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_character,
   output logic                                  rsp_last
);

   // front -> queue
   logic                   push_valid, push_stall;
   dta_pkg::dta_entry_type push_entry;
   // queue -> back
   logic                   pop_valid, pop_stall;
   dta_pkg::dta_entry_type pop_entry;

   // sign split and magnitude
   dta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_entry (push_entry)
   );

   // decouples intake from the slow conversion/emit path
   dta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_entry  (pop_entry)
   );

   // binary to BCD, then characters into the output register
   dta_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_stall     (pop_stall),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

>>> src/dta_front.sv
// ---------------------------------------------------------------------------
// dta_front: input stage
// Takes request words, splits sign and unsigned magnitude, holds one entry.
// ---------------------------------------------------------------------------
module dta_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [dta_pkg::ValueWidth-1:0] req_value,
   output logic                                 push_valid,
   input  logic                                 push_stall,
   output dta_pkg::dta_entry_type               push_entry
);

   logic                   f_valid_ff, f_valid_in;
   dta_pkg::dta_entry_type f_entry_ff, f_entry_in;
   logic                   accept;
   logic [dta_pkg::ValueWidth-1:0] raw;

   assign req_stall = f_valid_ff && push_stall;
   assign accept    = req_valid && !req_stall;
   assign raw       = $unsigned(req_value);

   always_comb begin
      f_valid_in = accept || (f_valid_ff && push_stall);
      f_entry_in = f_entry_ff;
      if (accept) begin
         f_entry_in.neg = raw[dta_pkg::ValueWidth-1];
         // magnitude is unsigned, so the most negative value fits
         f_entry_in.mag = raw[dta_pkg::ValueWidth-1] ?
                          ({dta_pkg::ValueWidth{1'b0}} - raw) : raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_entry_ff <= f_entry_in;
   end

   assign push_valid = f_valid_ff;
   assign push_entry = f_entry_ff;

endmodule

>>> src/dta_queue.sv
// ---------------------------------------------------------------------------
// dta_queue: two-entry queue between front and back
// Lets the front take a new word while the back is still converting.
// ---------------------------------------------------------------------------
module dta_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_stall,
   input  dta_pkg::dta_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_stall,
   output dta_pkg::dta_entry_type pop_entry
);

   dta_pkg::dta_entry_type            mem_ff [dta_pkg::QueueDepth];
   logic [dta_pkg::QPtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dta_pkg::QPtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dta_pkg::QCntWidth-1:0]     cnt_ff, cnt_in;
   logic                              push, pop;

   assign push_stall = (cnt_ff == dta_pkg::QCntWidth'(dta_pkg::QueueDepth));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/dta_back.sv
// ---------------------------------------------------------------------------
// dta_back: bit-serial BCD conversion and character output
// Shift-add-3 over one bit per cycle, then sign if negative and digits, MSD first.
// ---------------------------------------------------------------------------
module dta_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_stall,
   input  dta_pkg::dta_entry_type pop_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last
);

   dta_pkg::dta_state_type            state_ff, state_in;
   logic [dta_pkg::ValueWidth-1:0]    bin_ff, bin_in;
   logic [dta_pkg::BcdWidth-1:0]      bcd_ff, bcd_in, bcd_adj;
   logic                              neg_ff, neg_in;
   logic [dta_pkg::StepWidth-1:0]     step_ff, step_in;
   logic [dta_pkg::IdxWidth-1:0]      idx_ff, idx_in, idx_top;
   logic                              out_valid_ff, out_valid_in;
   logic [7:0]                        out_char_ff, out_char_in;
   logic                              out_last_ff, out_last_in;
   logic                              slot_free;
   logic [3:0]                        digit;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign pop_stall = (state_ff != dta_pkg::ST_IDLE);
   assign digit     = bcd_ff[{idx_ff, 2'b00} +: 4];

   // add 3 to every digit of 5 or more, then shift in the next binary bit
   always_comb begin
      for (int d = 0; d < dta_pkg::NumDigits; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= dta_pkg::AdjThreshold) ?
                             bcd_ff[4*d +: 4] + dta_pkg::AdjOffset :
                             bcd_ff[4*d +: 4];
      end
   end

   // position of the leading nonzero digit of the finished result
   always_comb begin
      idx_top = '0;
      for (int d = 0; d < dta_pkg::NumDigits; d++) begin
         if (bcd_in[4*d +: 4] != 4'd0) begin
            idx_top = dta_pkg::IdxWidth'(d);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (state_ff == dta_pkg::ST_CONV) begin
         bcd_in = {bcd_adj[dta_pkg::BcdWidth-2:0], bin_ff[dta_pkg::ValueWidth-1]};
      end
      unique case (state_ff)
         dta_pkg::ST_IDLE: begin
            if (pop_valid) begin
               bin_in   = pop_entry.mag;
               neg_in   = pop_entry.neg;
               bcd_in   = '0;
               step_in  = '0;
               state_in = dta_pkg::ST_CONV;
            end
         end
         dta_pkg::ST_CONV: begin
            bin_in  = {bin_ff[dta_pkg::ValueWidth-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == dta_pkg::StepWidth'(dta_pkg::ValueWidth - 1)) begin
               idx_in   = idx_top;
               state_in = neg_ff ? dta_pkg::ST_SIGN : dta_pkg::ST_DIGIT;
            end
         end
         dta_pkg::ST_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = dta_pkg::AsciiMinus;
               out_last_in  = 1'b0;
               state_in     = dta_pkg::ST_DIGIT;
            end
         end
         dta_pkg::ST_DIGIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = dta_pkg::AsciiZero + {4'd0, digit};
               out_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = dta_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = dta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dta_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;

endmodule

>>> src/dta_checker.sv
// ---------------------------------------------------------------------------
// dta_checker: port-level checks for the decimal ASCII converter
// Bound to the top level; watches the request and response streams.
// ---------------------------------------------------------------------------
module dta_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [dta_pkg::ValueWidth-1:0] req_value,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [7:0]                            rsp_character,
   input logic                                  rsp_last
);

   logic is_minus, is_digit;

   assign is_minus = (rsp_character == dta_pkg::AsciiMinus);
   assign is_digit = (rsp_character >= dta_pkg::AsciiZero) &&
                     (rsp_character <= dta_pkg::AsciiZero + 8'd9);

   // stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_value))
      else $error("request word changed while stalled");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // only '-' or a digit ever appears
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> is_minus || is_digit)
      else $error("response character out of range");

   // a sign is never the end of a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_minus |-> !rsp_last)
      else $error("minus sign flagged last");

   // an accepted sign is never directly followed by another sign
   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && is_minus |=> !(rsp_valid && is_minus))
      else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii_top dta_checker u_dta_checker (.*);
